### sv/assert_macros.svh
// assertion macros used by the top level of the signal decoder
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// condition in the same cycle implies consequence in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// condition implies consequence in the following cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

### sv/csx_pkg.sv
// shared types and constants of the can signal decoder
// used by csx_extract, csx_scale and can_signal_extract_scale
`default_nettype none

package csx_pkg;

    localparam int WORD_W     = 64;
    localparam int RAW_W      = 32;
    localparam int GAIN_W     = 32;
    localparam int BIAS_W     = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_BYTES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_BIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_BITS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BIG_ENDIAN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS        = 3'd5;

    // reset values
    localparam logic [3:0]               RST_FRAME_BYTES = 4'd8;
    localparam logic [5:0]               RST_START_BIT   = 6'd0;
    localparam logic [5:0]               RST_SIGNAL_BITS = 6'd16;
    localparam logic                     RST_BIG_ENDIAN  = 1'b0;
    localparam logic signed [GAIN_W-1:0] RST_GAIN        = 32'sd65536;
    localparam logic signed [BIAS_W-1:0] RST_BIAS        = 48'sd0;

    typedef struct packed {
        logic [3:0]               frame_bytes;
        logic [5:0]               start_bit;
        logic [5:0]               signal_bits;
        logic                     big_endian;
        logic signed [GAIN_W-1:0] gain;
        logic signed [BIAS_W-1:0] bias;
    } cfg_t;

    // extracted raw signal with its status
    typedef struct packed {
        logic             ok;
        logic [RAW_W-1:0] raw;
    } raw_item_t;

endpackage

`default_nettype wire

### sv/csx_extract.sv
// byte reversal and signal extraction, two pipeline stages
// depends on csx_pkg
`default_nettype none

module csx_extract (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire csx_pkg::cfg_t                   cfg,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [csx_pkg::WORD_W-1:0]      in_word,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output csx_pkg::raw_item_t                   out_item
);

    logic                         s1_valid_reg;
    logic [csx_pkg::WORD_W-1:0]   s1_word_reg;
    logic [csx_pkg::WORD_W-1:0]   s1_word_next;
    logic                         s1_ok_reg;
    logic                         s1_ok_next;
    logic                         s1_ready;

    logic                         s2_valid_reg;
    csx_pkg::raw_item_t           s2_item_reg;
    csx_pkg::raw_item_t           s2_item_next;
    logic                         s2_ready;

    logic signed [7:0]            be_shift;
    logic                         use_be;
    logic [csx_pkg::RAW_W-1:0]    mask;
    logic                         mask_ok;
    logic [csx_pkg::WORD_W-1:0]   shifted;
    logic [csx_pkg::RAW_W-1:0]    raw;
    logic                         be_ok;

    // reverse the low n bytes, bytes at n and above become zero
    function automatic logic [csx_pkg::WORD_W-1:0] rev_bytes(
        input logic [csx_pkg::WORD_W-1:0] w,
        input int                         n
    );
        logic [csx_pkg::WORD_W-1:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            if (i < n) begin
                r[8*(n-1-i) +: 8] = w[8*i +: 8];
            end
        end
        return r;
    endfunction

    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_ready  = s1_ready;
    assign out_valid = s2_valid_reg;
    assign out_item  = s2_item_reg;

    // stage 1: frame reversal
    always_comb begin
        s1_word_next = in_word;
        s1_ok_next   = 1'b1;
        case (cfg.frame_bytes)
            4'd8: s1_word_next = rev_bytes(in_word, 8);
            4'd7: s1_word_next = rev_bytes(in_word, 7);
            4'd6: s1_word_next = rev_bytes(in_word, 6);
            4'd4: s1_word_next = rev_bytes(in_word, 4);
            default: begin
                s1_word_next = in_word;
                s1_ok_next   = 1'b0;
            end
        endcase
    end

    // stage 2: shift, mask and motorola swap
    always_comb begin
        mask    = '0;
        mask_ok = 1'b1;
        case (cfg.signal_bits)
            6'd1:  mask = 32'h0000_0001;
            6'd3:  mask = 32'h0000_0007;
            6'd8:  mask = 32'h0000_00ff;
            6'd16: mask = 32'h0000_ffff;
            6'd32: mask = 32'hffff_ffff;
            default: begin
                mask    = '0;
                mask_ok = 1'b0;
            end
        endcase

        be_shift = $signed({2'b00, cfg.start_bit}) + 8'sd8
                   - $signed({2'b00, cfg.signal_bits});
        use_be   = cfg.big_endian && (cfg.signal_bits > 6'd1);
        be_ok    = 1'b1;

        if (use_be) begin
            if (be_shift[7]) begin
                shifted = '0;
                be_ok   = 1'b0;
            end else if (be_shift[6]) begin
                // shift of 64 or more clears everything
                shifted = '0;
            end else begin
                shifted = s1_word_reg >> be_shift[5:0];
            end
            raw = shifted[csx_pkg::RAW_W-1:0] & mask;
            if (cfg.signal_bits == 6'd16) begin
                raw = {16'h0000, raw[7:0], raw[15:8]};
            end else begin
                be_ok = 1'b0;
            end
        end else begin
            shifted = s1_word_reg >> cfg.start_bit;
            raw     = shifted[csx_pkg::RAW_W-1:0] & mask;
        end

        s2_item_next.raw = raw;
        s2_item_next.ok  = s1_ok_reg && mask_ok && be_ok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready && in_valid) begin
            s1_word_reg <= s1_word_next;
            s1_ok_reg   <= s1_ok_next;
        end
        if (s2_ready && s1_valid_reg) begin
            s2_item_reg <= s2_item_next;
        end
    end

endmodule

`default_nettype wire

### sv/csx_scale.sv
// gain multiply and saturating bias add, two pipeline stages
// depends on csx_pkg
`default_nettype none

module csx_scale (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire csx_pkg::cfg_t                   cfg,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire csx_pkg::raw_item_t              in_item,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [csx_pkg::WORD_W-1:0]           phys_value,
    output logic                                 valid_ok
);

    logic                                s3_valid_reg;
    logic signed [csx_pkg::WORD_W-1:0]   s3_prod_reg;
    logic signed [csx_pkg::WORD_W-1:0]   s3_prod_next;
    logic                                s3_ok_reg;
    logic                                s3_ready;

    logic                                s4_valid_reg;
    logic [csx_pkg::WORD_W-1:0]          s4_value_reg;
    logic [csx_pkg::WORD_W-1:0]          s4_value_next;
    logic                                s4_ok_reg;
    logic                                s4_ready;

    logic signed [csx_pkg::WORD_W:0]     prod_full;
    logic signed [csx_pkg::WORD_W:0]     sum_full;

    assign s4_ready   = !s4_valid_reg || out_ready;
    assign s3_ready   = !s3_valid_reg || s4_ready;
    assign in_ready   = s3_ready;
    assign out_valid  = s4_valid_reg;
    assign phys_value = s4_value_reg;
    assign valid_ok   = s4_ok_reg;

    // raw is unsigned 32 bit, so the product always fits in 64 bits
    always_comb begin
        prod_full    = $signed({1'b0, in_item.raw}) * cfg.gain;
        s3_prod_next = prod_full[csx_pkg::WORD_W-1:0];
    end

    always_comb begin
        sum_full = {s3_prod_reg[csx_pkg::WORD_W-1], s3_prod_reg}
                 + {{(csx_pkg::WORD_W + 1 - csx_pkg::BIAS_W){cfg.bias[csx_pkg::BIAS_W-1]}},
                    cfg.bias};
        if (sum_full[csx_pkg::WORD_W] != sum_full[csx_pkg::WORD_W-1]) begin
            // overflow, clamp towards the sign of the true sum
            s4_value_next = sum_full[csx_pkg::WORD_W] ? {1'b1, {(csx_pkg::WORD_W-1){1'b0}}}
                                                      : {1'b0, {(csx_pkg::WORD_W-1){1'b1}}};
        end else begin
            s4_value_next = sum_full[csx_pkg::WORD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else begin
            if (s3_ready) begin
                s3_valid_reg <= in_valid;
            end
            if (s4_ready) begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_ready && in_valid) begin
            s3_prod_reg <= s3_prod_next;
            s3_ok_reg   <= in_item.ok;
        end
        if (s4_ready && s3_valid_reg) begin
            s4_value_reg <= s4_value_next;
            s4_ok_reg    <= s3_ok_reg;
        end
    end

endmodule

`default_nettype wire

### sv/can_signal_extract_scale.sv
// top level of the can signal decoder: configuration registers and pipeline
// depends on csx_pkg, csx_extract, csx_scale and assert_macros.svh
//
// usage:
//   s_ channel carries one 64-bit can payload per request, first byte in the
//   most significant bits. m_ channel returns one result per request:
//   m_tdata is the signed q48.16 physical value, m_tuser[0] is set when
//   frame length and signal settings are all supported.
//   configuration is written through cfg_we / cfg_index / cfg_wdata, one
//   register per cycle; the user writes it only while no request is in
//   flight, and the block itself does not enforce this.
//   pipeline: four register stages (reversal, extraction, multiply,
//   bias add with saturation).
//   throughput: one request per cycle while m_tready is high; every stage
//   passes on one request a cycle and the 33x32 multiply has its own stage.
//   reset: aresetn low for one edge empties the pipeline and loads the
//   register defaults (8-byte frame, start bit 0, 16-bit little-endian
//   signal, gain 1.0, bias 0).
//   stall: with m_tready low, each stage holds its request and the pipeline
//   keeps accepting until every stage is full, then s_tready drops; nothing
//   is lost or repeated.
`default_nettype none

`include "assert_macros.svh"

module can_signal_extract_scale (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [csx_pkg::WORD_W-1:0]         s_tdata,   // [63:0] frame_word
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [csx_pkg::WORD_W-1:0]              m_tdata,   // [63:0] phys_value
    output logic [0:0]                              m_tuser,   // [0] valid_ok
    input  wire logic                               cfg_we,
    input  wire logic [csx_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [csx_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    csx_pkg::cfg_t        cfg_reg;
    csx_pkg::cfg_t        cfg_next;

    logic                 ext_valid;
    logic                 ext_ready;
    csx_pkg::raw_item_t   ext_item;
    logic                 scl_ok;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                csx_pkg::REG_FRAME_BYTES: cfg_next.frame_bytes = cfg_wdata[3:0];
                csx_pkg::REG_START_BIT:   cfg_next.start_bit   = cfg_wdata[5:0];
                csx_pkg::REG_SIGNAL_BITS: cfg_next.signal_bits = cfg_wdata[5:0];
                csx_pkg::REG_BIG_ENDIAN:  cfg_next.big_endian  = cfg_wdata[0];
                csx_pkg::REG_GAIN:
                    cfg_next.gain = $signed(cfg_wdata[csx_pkg::GAIN_W-1:0]);
                csx_pkg::REG_BIAS:
                    cfg_next.bias = $signed(cfg_wdata[csx_pkg::BIAS_W-1:0]);
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_bytes <= csx_pkg::RST_FRAME_BYTES;
            cfg_reg.start_bit   <= csx_pkg::RST_START_BIT;
            cfg_reg.signal_bits <= csx_pkg::RST_SIGNAL_BITS;
            cfg_reg.big_endian  <= csx_pkg::RST_BIG_ENDIAN;
            cfg_reg.gain        <= csx_pkg::RST_GAIN;
            cfg_reg.bias        <= csx_pkg::RST_BIAS;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    csx_extract u_extract (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_word   (s_tdata),
        .out_valid (ext_valid),
        .out_ready (ext_ready),
        .out_item  (ext_item)
    );

    csx_scale u_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (ext_valid),
        .in_ready   (ext_ready),
        .in_item    (ext_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .phys_value (m_tdata),
        .valid_ok   (scl_ok)
    );

    assign m_tuser[0] = scl_ok;

    // input side only blocks when the output is holding a stalled result
    `ASSERT_IMPLIES(a_block_only_on_stall, aclk, aresetn, !s_tready, m_tvalid && !m_tready)

    // a result flagged good implies a supported frame length
    `ASSERT_IMPLIES(a_ok_frame_len, aclk, aresetn, m_tvalid && m_tuser[0], cfg_reg.frame_bytes == 4'd8 || cfg_reg.frame_bytes == 4'd7 || cfg_reg.frame_bytes == 4'd6 || cfg_reg.frame_bytes == 4'd4)

    // zero gain leaves only the sign-extended bias
    `ASSERT_IMPLIES(a_zero_gain_bias, aclk, aresetn, m_tvalid && cfg_reg.gain == 32'sd0, $signed(m_tdata) == 64'(cfg_reg.bias))

endmodule

`default_nettype wire
